[sv/per_channel_rate_ema_tracker_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the channel rate tracker
// Each macro expands to a labeled concurrent assertion, or to nothing in SYNTH.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_RATE_EMA_TRACKER_CORE_MACROS_SVH
`define PER_CHANNEL_RATE_EMA_TRACKER_CORE_MACROS_SVH
`ifndef SYNTH
`define PCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/pcr_ema_pkg.sv]
// ----------------------------------------------------------------------------
// Channel rate tracker package
// Shared types, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none
package pcr_ema_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam logic [16:0] ALPHA_RST = 17'd5243;
    localparam logic [8:0]  CORES_RST = 9'd1;
    localparam logic [15:0] MIN_IV_RST = 16'd20;
    localparam logic [29:0] TOTAL_MAX = 30'h3FFF_FFFF;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_OBS   = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam logic [2:0] ST_STARTED = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_RESET   = 3'd2;
    localparam logic [2:0] ST_CLKBACK = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;
    localparam logic [2:0] ST_UPDATED = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;
    localparam logic [2:0] ST_ENDED   = 3'd7;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_CORES = 2'd1;
    localparam logic [1:0] REG_MINIV = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] channel_key;
        logic [39:0] busy_time_ms;
        logic [47:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [24:0] entry_usage;
        logic        entry_known;
        logic [29:0] total_usage;
        logic        total_known;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SCAN, S_CMP, S_READ, S_EVAL, S_DIV, S_MUL, S_MIX,
        S_WALK, S_WALKRD, S_DONE
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // capture the input item
        logic do_start;   // compute elapsed, begin seen clear
        logic scan_cmp;   // compare the key read on the previous cycle
        logic scan_step;  // read key at index, advance
        logic rd;         // issue memory read of chosen entry
        logic eval;       // classify the observation
        logic div_step;   // one quotient bit
        logic mul;        // blend products
        logic mix;        // finish blend and write back
        logic walk_rd;    // read entry at walk index
        logic walk_step;  // accumulate / drop entry
        logic finish;     // end-of-scan bookkeeping
        logic emit;       // present the result beat
    } t_ctl;

    // Datapath -> controller status
    typedef struct packed {
        logic idx_last;   // index at final entry
        logic need_div;   // observation goes to the sample path
        logic div_last;   // last quotient bit
    } t_sts;
endpackage
`default_nettype wire

[sv/pcr_ema_ctrl.sv]
// ----------------------------------------------------------------------------
// Channel rate tracker controller
// Sequences start, observation and end commands over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module pcr_ema_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_go,
    input  wire logic [1:0]             i_cmd,
    input  wire pcr_ema_pkg::t_sts      i_sts,
    output pcr_ema_pkg::t_ctl           o_ctl,
    output logic                        o_busy
);
    import pcr_ema_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_go) begin
                    o_ctl.load = 1'b1;
                    case (i_cmd)
                        CMD_START: n_state = S_CLEAR;
                        CMD_OBS:   n_state = S_SCAN;
                        CMD_END:   n_state = S_WALK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_ctl.do_start = 1'b1;
                o_ctl.emit = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                o_ctl.scan_cmp = 1'b1;
                if (i_sts.idx_last) n_state = S_CMP;
            end
            S_CMP: begin
                // compare the last key read
                o_ctl.scan_cmp = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_ctl.rd = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_ctl.eval = 1'b1;
                if (i_sts.need_div) begin
                    n_state = S_DIV;
                end else begin
                    o_ctl.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                o_ctl.mix = 1'b1;
                n_state = S_DONE;
            end
            S_WALK: begin
                o_ctl.walk_rd = 1'b1;
                n_state = S_WALKRD;
            end
            S_WALKRD: begin
                o_ctl.walk_step = 1'b1;
                if (i_sts.idx_last) begin
                    o_ctl.finish = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_DONE: begin
                o_ctl.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[sv/pcr_ema_dp.sv]
// ----------------------------------------------------------------------------
// Channel rate tracker datapath
// Entry table, key search, bit-serial divider, blend and end-of-scan walk.
// ----------------------------------------------------------------------------
`default_nettype none
module pcr_ema_dp #(
    parameter int ENTRIES = pcr_ema_pkg::ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire pcr_ema_pkg::t_in_item  i_item,
    input  wire pcr_ema_pkg::t_ctl      i_ctl,
    input  wire logic [16:0]            i_alpha,
    input  wire logic [8:0]             i_cores,
    input  wire logic [15:0]            i_min_iv,
    output pcr_ema_pkg::t_sts           o_sts,
    output pcr_ema_pkg::t_out_item      o_res,
    output logic                        o_res_valid
);
    import pcr_ema_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
    localparam int QW = 56;  // quotient bits of (delta << 16)

    // key/busy/rate memory, one read port
    logic [31:0] r_key_mem  [ENTRIES];
    logic [39:0] r_busy_mem [ENTRIES];
    logic [24:0] r_rate_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid, r_seen, r_known;

    t_in_item    r_item;
    logic [47:0] r_last;
    logic [48:0] r_elapsed;
    logic [IW-1:0] r_idx, r_hit, r_free;
    logic r_found, r_has_free;
    logic [31:0] r_rd_key;
    logic [IW-1:0] r_scan_idx;
    logic r_scan_v;
    logic [39:0] r_rd_busy;
    logic [24:0] r_rd_rate;
    logic [IW-1:0] r_rd_idx;
    logic [5:0]  r_bit;
    logic [55:0] r_quo;
    logic [48:0] r_rem;
    logic [55:0] r_dvd;
    logic [41:0] r_p0, r_p1;
    logic [29:0] r_total;
    logic r_any;
    t_out_item r_res;
    logic r_res_v;

    logic [IW-1:0] w_rd_addr;
    logic        w_neg, w_short;
    logic [39:0] w_delta;
    logic [24:0] w_cap;
    logic [16:0] w_a;
    logic [49:0] w_trial;
    logic [24:0] w_sample;
    logic [42:0] w_mix;
    logic [30:0] w_sum;
    t_out_item   w_eval_res;

    assign w_rd_addr = i_ctl.walk_rd ? r_idx : (r_found ? r_hit : r_free);
    assign w_neg   = r_elapsed[48];
    assign w_short = !w_neg && (r_elapsed < {33'd0, i_min_iv});
    assign w_delta = r_item.busy_time_ms - r_rd_busy;
    assign w_cap   = {i_cores, 16'd0};
    assign w_a     = (i_alpha > 17'd65536) ? 17'd65536 : i_alpha;
    assign w_trial = {r_rem, r_dvd[55]} - {1'b0, r_elapsed};
    assign w_mix   = {1'b0, r_p0} + {1'b0, r_p1} + 43'd32768;
    assign w_sum   = {1'b0, r_total} + {6'd0, r_rd_rate};

    always_comb begin
        if (r_elapsed == '0) begin
            w_sample = (w_delta != '0) ? w_cap : '0;
        end else if (r_quo > {31'd0, w_cap}) begin
            w_sample = w_cap;
        end else begin
            w_sample = r_quo[24:0];
        end
    end

    // classify the observation; the sample path fills status later
    always_comb begin
        w_eval_res = '0;
        if (!r_found) begin
            w_eval_res.status = r_has_free ? ST_NEW : ST_FULL;
        end else if (r_item.busy_time_ms < r_rd_busy) begin
            w_eval_res.status = ST_RESET;
        end else if (w_neg) begin
            w_eval_res.status = ST_CLKBACK;
        end else if (w_short) begin
            w_eval_res.status = ST_SHORT;
            w_eval_res.entry_known = r_known[r_rd_idx];
            w_eval_res.entry_usage = r_known[r_rd_idx] ? r_rd_rate : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd || i_ctl.walk_rd) begin
            r_rd_busy <= r_busy_mem[w_rd_addr];
            r_rd_rate <= r_rate_mem[w_rd_addr];
            r_rd_idx  <= w_rd_addr;
        end
        if (i_ctl.scan_step) begin
            r_rd_key   <= r_key_mem[r_idx];
            r_scan_idx <= r_idx;
        end
        if (i_ctl.eval) begin
            if (!r_found && r_has_free) begin
                r_key_mem[r_free]  <= r_item.channel_key;
                r_busy_mem[r_free] <= r_item.busy_time_ms;
            end else if (r_found && (r_item.busy_time_ms < r_rd_busy || w_neg)) begin
                r_busy_mem[r_rd_idx] <= r_item.busy_time_ms;
            end
        end
        if (i_ctl.mix) begin
            r_busy_mem[r_rd_idx] <= r_item.busy_time_ms;
            r_rate_mem[r_rd_idx] <= r_known[r_rd_idx] ? w_mix[40:16] : w_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_seen <= '0; r_known <= '0;
            r_last <= '0; r_elapsed <= '0; r_idx <= '0;
            r_found <= 1'b0; r_has_free <= 1'b0; r_scan_v <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= i_ctl.emit;
            if (i_ctl.load) begin
                r_item <= i_item;
                r_idx <= '0;
                r_found <= 1'b0;
                r_has_free <= 1'b0;
                r_scan_v <= 1'b0;
                r_total <= '0;
                r_any <= 1'b0;
            end
            if (i_ctl.do_start) begin
                r_elapsed <= {1'b0, r_item.now_ms} - {1'b0, r_last};
                r_seen <= '0;
                r_res <= '{status: ST_STARTED, default: '0};
            end
            if (i_ctl.scan_cmp && r_scan_v) begin
                // key read last cycle: keep the first valid match
                if (!r_found && r_valid[r_scan_idx] && r_rd_key == r_item.channel_key) begin
                    r_found <= 1'b1;
                    r_hit <= r_scan_idx;
                end
            end
            if (i_ctl.scan_step) begin
                // one entry a cycle: read key, note lowest free slot
                r_scan_v <= 1'b1;
                if (!r_has_free && !r_valid[r_idx]) begin
                    r_has_free <= 1'b1;
                    r_free <= r_idx;
                end
                if (r_idx != LAST) r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.eval) begin
                r_res <= w_eval_res;
                if (!r_found) begin
                    if (r_has_free) begin
                        r_valid[r_free] <= 1'b1;
                        r_seen[r_free] <= 1'b1;
                        r_known[r_free] <= 1'b0;
                    end
                end else begin
                    r_seen[r_rd_idx] <= 1'b1;
                    if (r_item.busy_time_ms < r_rd_busy || w_neg) begin
                        r_known[r_rd_idx] <= 1'b0;
                    end
                end
                r_bit <= 6'(QW - 1);
                r_quo <= '0;
                r_rem <= '0;
                r_dvd <= {w_delta, 16'd0};
            end
            if (i_ctl.div_step) begin
                // restoring division, one quotient bit a cycle
                if (!w_trial[49]) begin
                    r_rem <= w_trial[48:0];
                    r_quo <= {r_quo[54:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[47:0], r_dvd[55]};
                    r_quo <= {r_quo[54:0], 1'b0};
                end
                r_dvd <= {r_dvd[54:0], 1'b0};
                r_bit <= r_bit - 1'b1;
            end
            if (i_ctl.mul) begin
                r_p0 <= 42'((17'd65536 - w_a) * r_rd_rate);
                r_p1 <= 42'(w_a * w_sample);
                r_res.entry_usage <= w_sample;
            end
            if (i_ctl.mix) begin
                r_known[r_rd_idx] <= 1'b1;
                r_res.status <= ST_UPDATED;
                r_res.entry_known <= 1'b1;
                if (r_known[r_rd_idx]) r_res.entry_usage <= w_mix[40:16];
            end
            if (i_ctl.walk_step) begin
                if (r_valid[r_rd_idx]) begin
                    if (!r_seen[r_rd_idx]) begin
                        r_valid[r_rd_idx] <= 1'b0;
                        r_known[r_rd_idx] <= 1'b0;
                    end else if (r_known[r_rd_idx]) begin
                        r_any <= 1'b1;
                        r_total <= w_sum[30] ? TOTAL_MAX : w_sum[29:0];
                    end
                end
                if (r_idx != LAST) r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.finish) begin
                if (!w_short) r_last <= r_last + r_elapsed[47:0];
            end
            if (i_ctl.emit && r_item.cmd == CMD_END) begin
                r_res <= '{status: ST_ENDED, entry_usage: '0, entry_known: 1'b0,
                           total_usage: r_total, total_known: r_any};
            end
        end
    end

    // The result for the end walk is formed from the final totals on emit.
    always_comb begin
        o_res = r_res;
        o_res_valid = r_res_v;
    end

    assign o_sts.idx_last = (r_idx == LAST);
    assign o_sts.need_div = r_found && !(r_item.busy_time_ms < r_rd_busy) && !w_neg && !w_short;
    assign o_sts.div_last = (r_bit == '0);
endmodule
`default_nettype wire

[sv/per_channel_rate_ema_tracker_core.sv]
// Observation: short paths, or the sample path through the bit-serial divider;
//   scan end does one memory read per entry in the walk.
// Throughput: one item at a time; busy drops in the result beat cycle.
// Result beat is a one-cycle o_done strobe; the receiver cannot stall.
// Reset: synchronous active-low; clears table valid bits and registers.
// ----------------------------------------------------------------------------
// Channel rate tracker top level
// Keyed channel table with smoothed busy-time usage rates, APB registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_channel_rate_ema_tracker_core_macros.svh"
module per_channel_rate_ema_tracker_core #(
    parameter int ENTRIES = pcr_ema_pkg::ENTRIES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire pcr_ema_pkg::t_in_item   i_item,
    output logic                         o_done,
    output pcr_ema_pkg::t_out_item       o_result,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pcr_ema_pkg::*;

    // configuration registers
    logic [16:0] r_alpha;
    logic [8:0]  r_cores;
    logic [15:0] r_min_iv;
    logic        w_wr;
    logic [1:0]  w_reg;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_busy;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_cores <= CORES_RST;
            r_min_iv <= MIN_IV_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_ALPHA: r_alpha <= pwdata[16:0];
                REG_CORES: r_cores <= pwdata[8:0];
                REG_MINIV: r_min_iv <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ALPHA: prdata = {15'd0, r_alpha};
            REG_CORES: prdata = {23'd0, r_cores};
            REG_MINIV: prdata = {16'd0, r_min_iv};
            default:   prdata = '0;
        endcase
    end

    // controller: accept on start && !busy
    pcr_ema_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .i_cmd   (i_item.cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy)
    );

    pcr_ema_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_ctl       (w_ctl),
        .i_alpha     (r_alpha),
        .i_cores     (r_cores),
        .i_min_iv    (r_min_iv),
        .o_sts       (w_sts),
        .o_res       (o_result),
        .o_res_valid (o_done)
    );

    assign busy = w_busy;

    // the result beat lands with the controller idle, ready for the next item
    `PCR_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // at most one result beat per command, never on consecutive cycles
    `PCR_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `PCR_ASSERT_IMPL(a_usage_known, i_clk, i_rst_n,
        o_done && !o_result.entry_known, o_result.entry_usage == '0)
endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Channel rate tracker testbench
// Drives scan-start, observation and scan-end beats with random gaps,
// predicts every result beat from an in-bench table model and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import pcr_ema_pkg::*;

    localparam int          NCH       = 64;
    localparam logic [1:0]  CMD_NONE  = 2'd3;   // unused code, yields no beat
    localparam int          POOL      = 80;     // more keys than table slots
    localparam int          TAIL_CYC  = 2 * NCH + 80;
    localparam int          WD_LIMIT  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_done;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    per_channel_rate_ema_tracker_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the channel table and the registers
    logic [31:0] sh_key   [NCH];
    logic        sh_valid [NCH];
    logic        sh_seen  [NCH];
    logic [39:0] sh_busy  [NCH];
    logic [24:0] sh_rate  [NCH];
    logic        sh_known [NCH];
    logic [47:0] sh_last_ms;
    longint      sh_elapsed;
    logic [16:0] cfg_alpha;
    logic [8:0]  cfg_cores;
    logic [15:0] cfg_miniv;

    t_in_item  pend_q[$];      // beats waiting for the driver
    t_out_item usage_exp_q[$]; // predicted result beats, oldest first

    logic   took = 1'b0;
    logic   no_idle = 1'b0;
    int     errors = 0;
    int     n_items = 0;
    int     n_results = 0;
    int     n_full = 0;
    int     n_updated = 0;
    int     wd_count = 0;

    // Stimulus bookkeeping
    logic [31:0] key_pool  [POOL];
    logic [39:0] busy_pool [POOL];
    logic [47:0] wall_ms = '0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Compute the beat one accepted item causes; update the shadow table.
    task automatic track_rate(input t_in_item it, output bit has_beat,
                              output t_out_item r);
        int          idx;
        logic [63:0] delta, el, cap, sample, a, total;
        logic        any;
        r = '0;
        has_beat = 1'b1;
        case (it.cmd)
            CMD_START: begin
                sh_elapsed = longint'({16'd0, it.now_ms}) - longint'({16'd0, sh_last_ms});
                for (int i = 0; i < NCH; i++) sh_seen[i] = 1'b0;
                r.status = ST_STARTED;
            end
            CMD_OBS: begin
                idx = -1;
                for (int i = 0; i < NCH; i++)
                    if (idx < 0 && sh_valid[i] && sh_key[i] == it.channel_key) idx = i;
                if (idx < 0) begin
                    for (int i = 0; i < NCH; i++)
                        if (idx < 0 && !sh_valid[i]) idx = i;
                    if (idx < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        sh_valid[idx] = 1'b1;
                        sh_seen[idx]  = 1'b1;
                        sh_key[idx]   = it.channel_key;
                        sh_busy[idx]  = it.busy_time_ms;
                        sh_rate[idx]  = '0;
                        sh_known[idx] = 1'b0;
                        r.status = ST_NEW;
                    end
                end else begin
                    sh_seen[idx] = 1'b1;
                    if (it.busy_time_ms < sh_busy[idx]) begin
                        sh_busy[idx] = it.busy_time_ms;
                        sh_rate[idx] = '0;
                        sh_known[idx] = 1'b0;
                        r.status = ST_RESET;
                    end else if (sh_elapsed < 0) begin
                        sh_busy[idx] = it.busy_time_ms;
                        sh_rate[idx] = '0;
                        sh_known[idx] = 1'b0;
                        r.status = ST_CLKBACK;
                    end else if (sh_elapsed < longint'(cfg_miniv)) begin
                        if (sh_known[idx]) begin
                            r.entry_usage = sh_rate[idx];
                            r.entry_known = 1'b1;
                        end
                        r.status = ST_SHORT;
                    end else begin
                        delta = 64'(it.busy_time_ms) - 64'(sh_busy[idx]);
                        el    = 64'(sh_elapsed);
                        cap   = 64'(cfg_cores) << 16;
                        a     = (cfg_alpha > 17'd65536) ? 64'd65536 : 64'(cfg_alpha);
                        if (el == 0) sample = (delta != 0) ? cap : 64'd0;
                        else         sample = (delta << 16) / el;
                        if (sample > cap) sample = cap;
                        if (sh_known[idx])
                            sample = ((64'd65536 - a) * 64'(sh_rate[idx]) + a * sample
                                      + 64'd32768) >> 16;
                        sh_rate[idx]  = sample[24:0];
                        sh_known[idx] = 1'b1;
                        sh_busy[idx]  = it.busy_time_ms;
                        r.entry_usage = sh_rate[idx];
                        r.entry_known = 1'b1;
                        r.status = ST_UPDATED;
                    end
                end
            end
            CMD_END: begin
                total = '0;
                any = 1'b0;
                for (int i = 0; i < NCH; i++) begin
                    if (sh_valid[i]) begin
                        if (!sh_seen[i]) begin
                            sh_valid[i] = 1'b0;
                            sh_known[i] = 1'b0;
                        end else if (sh_known[i]) begin
                            any = 1'b1;
                            total += 64'(sh_rate[i]);
                            if (total > 64'(TOTAL_MAX)) total = 64'(TOTAL_MAX);
                        end
                    end
                end
                if (sh_elapsed < 0 || sh_elapsed >= longint'(cfg_miniv))
                    sh_last_ms = sh_last_ms + sh_elapsed[47:0];
                r.status = ST_ENDED;
                r.total_usage = total[29:0];
                r.total_known = any;
            end
            default: has_beat = 1'b0;
        endcase
    endtask

    // Driver: present the next pending beat at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (pend_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 19)) begin
                i_item <= pend_q.pop_front();
                start  <= 1'b1;
            end else begin
                start  <= 1'b0;
            end
        end
    end

    // Monitor: check result beats first, then predict the beat accepted now.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got_beat;
        bit        has_beat;
        if (i_rst_n) begin
            took <= start && !busy;
            if (o_done) begin
                got_beat = o_result;
                n_results++;
                if (usage_exp_q.size() == 0) begin
                    report("unexpected beat", got_beat, 0);
                end else begin
                    want = usage_exp_q.pop_front();
                    if (got_beat.status != want.status)
                        report("status", got_beat.status, want.status);
                    if (got_beat.entry_usage != want.entry_usage)
                        report("entry_usage", got_beat.entry_usage, want.entry_usage);
                    if (got_beat.entry_known != want.entry_known)
                        report("entry_known", got_beat.entry_known, want.entry_known);
                    if (got_beat.total_usage != want.total_usage)
                        report("total_usage", got_beat.total_usage, want.total_usage);
                    if (got_beat.total_known != want.total_known)
                        report("total_known", got_beat.total_known, want.total_known);
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_UPDATED) n_updated++;
                end
            end
            if (start && !busy) begin
                n_items++;
                track_rate(i_item, has_beat, want);
                if (has_beat) usage_exp_q.push_back(want);
            end
            // Watchdog: count cycles without an accepted input beat or a result beat.
            if ((start && !busy) || o_done) wd_count <= 0;
            else wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT) begin
                $display("watchdog expired with %0d beats outstanding", usage_exp_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic push_beat(input logic [1:0] cmd, input logic [31:0] key,
                             input logic [39:0] bt, input logic [47:0] now);
        t_in_item it;
        it.cmd = cmd;
        it.channel_key = key;
        it.busy_time_ms = bt;
        it.now_ms = now;
        pend_q.push_back(it);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ALPHA: cfg_alpha = val[16:0];
            REG_CORES: cfg_cores = val[8:0];
            default:   cfg_miniv = val[15:0];
        endcase
    endtask

    task automatic set_config(input logic [16:0] al, input logic [8:0] co,
                              input logic [15:0] mi);
        apb_write(REG_ALPHA, 32'(al));
        apb_write(REG_CORES, 32'(co));
        apb_write(REG_MINIV, 32'(mi));
    endtask

    // Wait until every pending beat has been taken and answered, then drain.
    task automatic drain();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || start || usage_exp_q.size() != 0);
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    // One scan over the first psize pool keys; mostly well formed.
    task automatic gen_scan(input int psize, input int nobs);
        int     sel, k;
        longint step, inc;
        sel = $urandom_range(0, 99);
        if (sel < 80)      step = longint'(cfg_miniv) + $urandom_range(0, 3 * cfg_miniv + 100);
        else if (sel < 90) step = $urandom_range(0, cfg_miniv);
        else if (sel < 96) step = -longint'($urandom_range(1, 1000));
        else               step = longint'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFFF;
        wall_ms = wall_ms + step[47:0];
        if ($urandom_range(0, 99) >= 4)
            push_beat(CMD_START, $urandom, 40'($urandom), wall_ms);
        for (int j = 0; j < nobs; j++) begin
            k = (nobs >= psize) ? j % psize : $urandom_range(0, psize - 1);
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                busy_pool[k] = busy_pool[k] - $urandom_range(1, 500);
            end else if (sel < 8) begin
                busy_pool[k] = 40'({$urandom, $urandom});
            end else begin
                inc = (longint'($urandom) % ((step < 0 ? 0 : step % 1000000) + 1))
                      * $urandom_range(0, cfg_cores + 1);
                busy_pool[k] = busy_pool[k] + inc[39:0];
            end
            push_beat(CMD_OBS, key_pool[k], busy_pool[k], 48'({$urandom, $urandom}));
        end
        if ($urandom_range(0, 99) < 3)
            push_beat(CMD_NONE, $urandom, 40'($urandom), 48'($urandom));
        if ($urandom_range(0, 99) >= 4)
            push_beat(CMD_END, $urandom, 40'($urandom), 48'($urandom));
    endtask

    initial begin
        int ph_items;
        for (int i = 0; i < NCH; i++) begin
            sh_key[i] = '0; sh_valid[i] = 1'b0; sh_seen[i] = 1'b0;
            sh_busy[i] = '0; sh_rate[i] = '0; sh_known[i] = 1'b0;
        end
        sh_last_ms = '0;
        sh_elapsed = 0;
        cfg_alpha = ALPHA_RST;
        cfg_cores = CORES_RST;
        cfg_miniv = MIN_IV_RST;
        for (int i = 0; i < POOL; i++) begin
            key_pool[i] = $urandom;
            busy_pool[i] = 40'({$urandom, $urandom}) & 40'h00_FFFF_FFFF;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset registers, short first scan, first sample,
        // counter backwards, clock backwards, widest timestamp, unused code.
        push_beat(CMD_START, 32'h0, 40'h0, 48'h0);
        push_beat(CMD_OBS, 32'h0, 40'h0, 48'h0);
        push_beat(CMD_OBS, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_beat(CMD_END, 32'h0, 40'h0, 48'h0);
        push_beat(CMD_START, 32'h0, 40'h0, 48'd100);
        push_beat(CMD_OBS, 32'h0, 40'd50, 48'h0);
        push_beat(CMD_OBS, 32'h0, 40'd40, 48'h0);
        push_beat(CMD_OBS, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 48'h0);
        push_beat(CMD_END, 32'h0, 40'h0, 48'h0);
        push_beat(CMD_START, 32'h0, 40'h0, 48'd50);
        push_beat(CMD_OBS, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 48'h0);
        push_beat(CMD_END, 32'h0, 40'h0, 48'h0);
        push_beat(CMD_START, 32'h0, 40'h0, 48'hFFFF_FFFF_FFFF);
        push_beat(CMD_OBS, 32'h0, 40'd1000, 48'h0);
        push_beat(CMD_OBS, 32'h0, 40'hFF_FFFF_FFFF, 48'h0);
        push_beat(CMD_NONE, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_beat(CMD_END, 32'h0, 40'h0, 48'h0);
        drain();
        wall_ms = sh_last_ms;

        // Random phases over several register settings, extremes included.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_config(17'd65536, 9'd256, 16'd0);
                1: set_config(17'd0, 9'd1, 16'd65535);
                2: set_config(17'h1FFFF, 9'd4, 16'd20);
                3: set_config(ALPHA_RST, 9'h1FF, 16'd1);
                default: set_config(17'($urandom_range(0, 131071)),
                                    9'($urandom_range(1, 511)),
                                    16'($urandom_range(0, 200)));
            endcase
            no_idle = (ph == 3);
            ph_items = pend_q.size();
            // Overfill the table in the first three settings to reach the full case.
            if (ph < 3) gen_scan(POOL, POOL);
            while (pend_q.size() - ph_items < 130)
                gen_scan($urandom_range(2, 20), $urandom_range(1, 10));
            drain();
            wall_ms = sh_last_ms;
        end

        $display("run covered %0d input beats and %0d result beats over 8 settings",
                 n_items, n_results);
        $display("%0d rate updates, %0d table-full beats", n_updated, n_full);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
